/* sv/rccb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rccb_pkg
// Shared types and constants for the random cyclic chain builder.
// ----------------------------------------------------------------------------
package rccb_pkg;

    localparam logic [63:0] DEFAULT_SEED = 64'h0000_dead_beef_cafe;
    localparam int          MAX_LINES    = 1024;
    localparam int          IDX_W        = 10;
    localparam int          CNT_W        = 11;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOCHAIN = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic       CMD_BUILD = 1'b0;
    localparam logic       CMD_QUERY = 1'b1;

    localparam logic       REG_SEED  = 1'b0;
    localparam logic       REG_LINES = 1'b1;

    typedef struct packed {
        logic             command;
        logic [IDX_W-1:0] line_index;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] next_line;
    } t_rsp;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load_req;   // capture the request, reload generator
        logic init_step;  // write identity entry, advance init counter
        logic gen_step;   // advance generator and start modulo
        logic div_step;   // one bit of the modulo
        logic rd_i;       // read perm[i]
        logic rd_j;       // read perm[j]
        logic wr_i;       // perm[i] <= perm[j]
        logic wr_j;       // perm[j] <= old perm[i]; step i down
        logic lk_rd;      // read perm[k] for the link pass
        logic lk_wr;      // write succ link, step k
        logic lk_cl;      // link the last entry back to the first
        logic q_rd;       // read successor
    } t_cmd;

    typedef struct packed {
        logic init_done;
        logic div_done;
        logic shuf_done;
        logic link_done;
    } t_sts;

endpackage

/* sv/rccb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rccb_ctrl
// Sequencer for build and query requests.
// ----------------------------------------------------------------------------
module rccb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic            i_req_cmd,
    input  logic            i_chain_ok,
    input  logic            i_out_free,
    input  rccb_pkg::t_sts  i_sts,
    output logic            o_req_ready,
    output logic            o_rsp_load,
    output logic            o_build_done,
    output rccb_pkg::t_cmd  o_cmd
);
    import rccb_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_INIT  = 14'b00000000000010,
        S_GEN   = 14'b00000000000100,
        S_DIV   = 14'b00000000001000,
        S_RDI   = 14'b00000000010000,
        S_RDJ   = 14'b00000000100000,
        S_WRI   = 14'b00000001000000,
        S_WRJ   = 14'b00000010000000,
        S_LRD   = 14'b00000100000000,
        S_LWR   = 14'b00001000000000,
        S_QRD   = 14'b00010000000000,
        S_QWT   = 14'b00100000000000,
        S_DONE  = 14'b01000000000000,
        S_LCL   = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_rsp_load   = 1'b0;
        o_build_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    if (i_req_cmd == CMD_BUILD) n_state = S_INIT;
                    else if (i_chain_ok)        n_state = S_QRD;
                    else                        n_state = S_DONE;
                end
            end
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_sts.init_done) n_state = S_GEN;
            end
            S_GEN: begin
                if (i_sts.shuf_done) n_state = S_LRD;
                else begin
                    o_cmd.gen_step = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_RDI;
            end
            S_RDI: begin
                o_cmd.rd_i = 1'b1;
                n_state = S_RDJ;
            end
            S_RDJ: begin
                o_cmd.rd_j = 1'b1;
                n_state = S_WRI;
            end
            S_WRI: begin
                o_cmd.wr_i = 1'b1;
                n_state = S_WRJ;
            end
            S_WRJ: begin
                o_cmd.wr_j = 1'b1;
                n_state = S_GEN;
            end
            S_LRD: begin
                o_cmd.lk_rd = 1'b1;
                n_state = S_LWR;
            end
            S_LWR: begin
                o_cmd.lk_wr = 1'b1;
                if (i_sts.link_done) n_state = S_LCL;
                else                 n_state = S_LRD;
            end
            S_LCL: begin
                o_cmd.lk_cl  = 1'b1;
                o_build_done = 1'b1;
                n_state = S_DONE;
            end
            S_QRD: begin
                o_cmd.q_rd = 1'b1;
                n_state = S_QWT;
            end
            S_QWT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_rsp_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

/* sv/rccb_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rccb_dp
// Generator, bit-serial modulo unit, permutation and successor memories.
// ----------------------------------------------------------------------------
module rccb_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rccb_pkg::t_cmd                       i_cmd,
    input  rccb_pkg::t_req                       i_req,
    input  logic [63:0]                          i_seed,
    input  logic [$clog2(rccb_pkg::MAX_LINES):0] i_lines,
    output rccb_pkg::t_sts                       o_sts,
    output logic                                 o_in_range,
    output logic [rccb_pkg::IDX_W-1:0]           o_next
);
    import rccb_pkg::*;

    localparam int AW = $clog2(MAX_LINES);

    logic [AW-1:0] r_perm [MAX_LINES];
    logic [AW-1:0] r_succ [MAX_LINES];

    logic [63:0]   r_gen;
    logic [AW-1:0] r_cnt;      // init index, then shuffle position i, then link k
    logic [AW-1:0] r_j;
    logic [AW-1:0] r_pi, r_pj, r_first, r_prev;
    logic [AW-1:0] r_qidx;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_rem;
    logic [63:0]   r_quo;
    logic [6:0]    r_bit;
    logic          r_lk_first;

    logic [63:0]   n_gen;
    logic [AW:0]   w_div;
    logic [AW+1:0] w_try;
    logic [AW-1:0] w_last;

    assign w_last = AW'(i_lines - 1'b1);
    assign w_div  = {1'b0, r_cnt} + 1'b1;
    assign w_try  = {r_rem, r_quo[63]} - {1'b0, w_div};

    always_comb begin
        n_gen = r_gen ^ (r_gen << 13);
        n_gen = n_gen ^ (n_gen >> 7);
        n_gen = n_gen ^ (n_gen << 17);
    end

    assign o_sts.init_done = (r_cnt == w_last);
    assign o_sts.div_done  = (r_bit == 7'd63);
    assign o_sts.shuf_done = (r_cnt == '0);
    assign o_sts.link_done = (r_cnt == w_last);
    assign o_in_range      = ({1'b0, i_req.line_index} < i_lines);
    assign o_next          = IDX_W'(r_rd);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_gen  <= (i_seed == '0) ? DEFAULT_SEED : i_seed;
            r_cnt  <= '0;
            r_qidx <= AW'(i_req.line_index);
        end
        if (i_cmd.init_step) begin
            r_perm[r_cnt] <= r_cnt;
            r_cnt <= o_sts.init_done ? r_cnt : r_cnt + 1'b1;
        end
        if (i_cmd.gen_step) begin
            r_gen <= n_gen;
            r_quo <= n_gen;
            r_rem <= '0;
            r_bit <= '0;
        end
        if (i_cmd.div_step) begin
            // Restoring division, one dividend bit per cycle.
            if (!w_try[AW+1]) r_rem <= w_try[AW:0];
            else              r_rem <= {r_rem[AW-1:0], r_quo[63]};
            r_quo <= {r_quo[62:0], 1'b0};
            r_bit <= r_bit + 1'b1;
            if (o_sts.div_done)
                r_j <= !w_try[AW+1] ? w_try[AW-1:0]
                                    : {r_rem[AW-2:0], r_quo[63]};
        end
        if (i_cmd.rd_i) r_pi <= r_perm[r_cnt];
        if (i_cmd.rd_j) r_pj <= r_perm[r_j];
        if (i_cmd.wr_i) r_perm[r_cnt] <= r_pj;
        if (i_cmd.wr_j) begin
            r_perm[r_j] <= r_pi;
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.lk_rd) r_pi <= r_perm[r_cnt];
        if (i_cmd.lk_wr) begin
            if (r_lk_first) r_first <= r_pi;
            else            r_succ[r_prev] <= r_pi;
            r_prev <= r_pi;
            r_cnt  <= r_cnt + 1'b1;
        end
        // Close the cycle: the last linked entry points back to the first.
        if (i_cmd.lk_cl) r_succ[r_prev] <= r_first;
        if (i_cmd.q_rd) r_rd <= r_succ[r_qidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)         r_lk_first <= 1'b1;
        else if (i_cmd.lk_wr) r_lk_first <= o_sts.link_done;
    end

endmodule

/* sv/random_cyclic_chain_builder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_cyclic_chain_builder
// Builds a shuffled single-cycle successor table and answers queries on it.
// ----------------------------------------------------------------------------
//  channel  | signals                          | payload
//  ---------+----------------------------------+-----------------
//  request  | i_in_valid / o_in_ready          | i_in (t_req)
//  response | o_out_valid / i_out_ready        | o_out (t_rsp)
//  config   | psel penable pwrite paddr pwdata | prdata, pready
//
// A build initialises, shuffles and links the L lines; the shuffle cost
// is set by the one-bit-per-cycle 64-bit modulo unit. Requests are taken
// one at a time. The response register frees the sequencer once loaded;
// a stalled response holds the next one.
// Reset is synchronous and active low; memories need no clearing.
module random_cyclic_chain_builder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rccb_pkg::t_req    i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rccb_pkg::t_rsp    o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    import rccb_pkg::*;

    localparam int AW = $clog2(MAX_LINES);

    logic [63:0]       r_seed;
    logic [CNT_W-1:0]  r_line_count;
    logic              r_chain_ok;
    logic [AW:0]       w_lines;
    logic              w_wr, w_reg;
    t_cmd              w_cmd;
    t_sts              w_sts;
    logic              w_in_range, w_rsp_load, w_build_done;
    logic [IDX_W-1:0]  w_next;
    logic              r_cmd;

    assign pready = 1'b1;
    assign w_reg  = paddr[3];
    assign w_wr   = psel && penable && pwrite;
    assign prdata = (w_reg == REG_SEED) ? r_seed : {{(64-CNT_W){1'b0}}, r_line_count};

    always_comb begin
        if (r_line_count < CNT_W'(2))              w_lines = (AW+1)'(2);
        else if ({5'd0, r_line_count} > 16'(MAX_LINES)) w_lines = (AW+1)'(MAX_LINES);
        else                                       w_lines = (AW+1)'(r_line_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed       <= '0;
            r_line_count <= CNT_W'(1024);
        end else if (w_wr) begin
            if (w_reg == REG_SEED) r_seed       <= pwdata;
            else                   r_line_count <= pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                        r_chain_ok <= 1'b0;
        else if (w_wr && w_reg == REG_LINES) r_chain_ok <= 1'b0;
        else if (w_build_done)               r_chain_ok <= 1'b1;
    end

    rccb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_in_valid),
        .i_req_cmd    (i_in.command),
        .i_chain_ok   (r_chain_ok),
        .i_out_free   (!o_out_valid || i_out_ready),
        .i_sts        (w_sts),
        .o_req_ready  (o_in_ready),
        .o_rsp_load   (w_rsp_load),
        .o_build_done (w_build_done),
        .o_cmd        (w_cmd)
    );

    rccb_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_req      (i_in),
        .i_seed     (r_seed),
        .i_lines    (w_lines),
        .o_sts      (w_sts),
        .o_in_range (w_in_range),
        .o_next     (w_next)
    );

    // Status decided at accept; range uses the incoming request index.
    logic [1:0] r_st;
    always_ff @(posedge i_clk) begin
        if (w_cmd.load_req) begin
            r_cmd <= i_in.command;
            if (i_in.command == CMD_BUILD) r_st <= ST_OK;
            else if (!r_chain_ok)          r_st <= ST_NOCHAIN;
            else if (!w_in_range)          r_st <= ST_RANGE;
            else                           r_st <= ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_rsp_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rsp_load) begin
            o_out.status    <= r_st;
            o_out.next_line <= (r_cmd == CMD_QUERY && r_st == ST_OK) ? w_next : '0;
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp_load |-> !w_cmd.load_req)
        else $error("response loaded while a request is accepted");
    a_ok_after_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_build_done && !(w_wr && w_reg == REG_LINES) |=> r_chain_ok)
        else $error("chain not marked after build");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.status != 2'd3)
        else $error("undefined status code");
`endif

endmodule
